>>> sv/tcvi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcvi_pkg
// shared constants and controller/datapath interface types for the
// clause vote inference unit
// ---------------------------------------------------------------------------
package tcvi_pkg;

  localparam int CLAUSES_DEFAULT  = 256;
  localparam int FEATURES_DEFAULT = 32;

  localparam int CFG_W   = 9;   // clauses_in_use
  localparam int INDEX_W = 8;   // clause_index
  localparam int MASK_W  = 32;  // include masks and feature vector
  localparam int SUM_W   = 9;   // vote_sum

  localparam int CFG_RESET = 256;

  // request kinds carried in tuser
  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  // configuration register indexes
  localparam int REG_CLAUSES_IN_USE = 0;

  typedef struct packed {
    logic clear_step;    // zero one store entry, advance sweep counter
    logic store_write;   // load one clause's masks from the request
    logic run_start;     // latch features, clear sum and clause counter
    logic run_step;      // read next clause if any remain
    logic result_load;   // move saturated sum into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;    // sweep counter on the final entry
    logic run_end;       // every clause in use has been read
    logic out_free;      // output register can take a result this cycle
  } sts_t;

endpackage

>>> sv/tcvi_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcvi_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module tcvi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tcvi_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcvi_ctrl
// controller: store clearing sweep after reset, request intake, clause
// pass sequencing and hand-off of the result to the output register
// ---------------------------------------------------------------------------
module tcvi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           req_type,
  input  tcvi_pkg::sts_t sts,
  output tcvi_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tready && s_tvalid;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type == tcvi_pkg::REQ_CLASSIFY) begin
            cmd.run_start = 1'b1;
            state_next    = ST_RUN;
          end else begin
            cmd.store_write = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        // last read accumulates at this edge
        if (sts.run_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_intake_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.store_write && !cmd.run_start)
    else $error("request taken outside idle");

  a_run_follows_start: assert property (@(posedge clk) disable iff (rst)
    cmd.run_start |=> (state == ST_RUN))
    else $error("classify request did not start a clause pass");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> sts.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

>>> sv/tcvi_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcvi_dp
// datapath: include store, clause counter, clause evaluation, vote
// accumulator with saturation and the output register
// ---------------------------------------------------------------------------
module tcvi_dp #(
  parameter int CLAUSES  = tcvi_pkg::CLAUSES_DEFAULT,
  parameter int FEATURES = tcvi_pkg::FEATURES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tcvi_pkg::cmd_t                 cmd,
  output tcvi_pkg::sts_t                 sts,
  input  logic [tcvi_pkg::CFG_W-1:0]     clauses_in_use,
  input  logic [tcvi_pkg::INDEX_W-1:0]   clause_index,
  input  logic [tcvi_pkg::MASK_W-1:0]    include_positive,
  input  logic [tcvi_pkg::MASK_W-1:0]    include_negated,
  input  logic [tcvi_pkg::MASK_W-1:0]    feature_bits,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic signed [tcvi_pkg::SUM_W-1:0] vote_sum,
  output logic                           prediction
);

  localparam int AW = $clog2(CLAUSES);
  localparam int CW = $clog2(CLAUSES + 1);
  localparam int SW = CW + 1;
  localparam int EW = (SW > tcvi_pkg::SUM_W) ? SW : tcvi_pkg::SUM_W;
  localparam logic signed [EW-1:0] SUM_HI = EW'(255);
  localparam logic signed [EW-1:0] SUM_LO = EW'(-256);

  logic [CW-1:0]            cnt;
  logic [CW-1:0]            limit;
  logic [FEATURES-1:0]      features;
  logic                     rd_valid;
  logic                     rd_odd;
  logic signed [SW-1:0]     acc;
  logic signed [EW-1:0]     acc_ext;
  logic signed [tcvi_pkg::SUM_W-1:0] sum_sat;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [2*FEATURES-1:0]    ram_wdata;
  logic                     ram_re;
  logic [2*FEATURES-1:0]    ram_rdata;
  logic [FEATURES-1:0]      pos;
  logic [FEATURES-1:0]      neg;
  logic                     fires;
  logic                     index_ok;

  // a limit above the store size counts as the store size
  assign limit = (32'(clauses_in_use) > CLAUSES) ? CW'(CLAUSES) : CW'(clauses_in_use);

  assign sts.clear_last = (cnt == CW'(CLAUSES - 1));
  assign sts.run_end    = (cnt >= limit);
  assign sts.out_free   = !m_tvalid || m_tready;

  assign index_ok  = (32'(clause_index) < CLAUSES);
  assign ram_we    = cmd.clear_step || (cmd.store_write && index_ok);
  assign ram_waddr = cmd.clear_step ? cnt[AW-1:0] : AW'(clause_index);
  assign ram_wdata = cmd.clear_step ? '0
                   : {include_negated[FEATURES-1:0], include_positive[FEATURES-1:0]};
  assign ram_re    = cmd.run_step && !sts.run_end;

  tcvi_ram #(
    .WIDTH (2 * FEATURES),
    .DEPTH (CLAUSES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign pos   = ram_rdata[FEATURES-1:0];
  assign neg   = ram_rdata[2*FEATURES-1:FEATURES];
  // empty clause never fires
  assign fires = ((pos | neg) != '0) && ((features & pos) == pos)
              && ((~features & neg) == neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ram_re;
      if (cmd.clear_step) begin
        cnt <= sts.clear_last ? '0 : cnt + 1'b1;
      end else if (cmd.run_start) begin
        cnt <= '0;
      end else if (ram_re) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_odd <= cnt[0];
    end
    if (cmd.run_start) begin
      features <= feature_bits[FEATURES-1:0];
      acc      <= '0;
    end else if (rd_valid && fires) begin
      acc <= rd_odd ? acc - SW'(1) : acc + SW'(1);
    end
  end

  assign acc_ext = EW'(acc);

  always_comb begin
    if (acc_ext > SUM_HI) begin
      sum_sat = tcvi_pkg::SUM_W'(SUM_HI);
    end else if (acc_ext < SUM_LO) begin
      sum_sat = tcvi_pkg::SUM_W'(SUM_LO);
    end else begin
      sum_sat = tcvi_pkg::SUM_W'(acc_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      vote_sum   <= sum_sat;
      prediction <= (sum_sat > 0);
    end
  end

`ifndef SYNTHESIS
  a_read_needs_step: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(cmd.run_step))
    else $error("store read without a clause step");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= CLAUSES)
    else $error("clause counter past store size");

  a_prediction_matches: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.result_load) |-> (prediction == (vote_sum > 0)))
    else $error("prediction does not follow vote sum");

  a_no_write_during_pass: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("store written during a clause pass");
`endif

endmodule

>>> sv/tsetlin_clause_vote_inference_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsetlin_clause_vote_inference_unit
// clause vote inference over an include store of clause literal masks
// ---------------------------------------------------------------------------
// requests arrive on the s_ group; tuser selects a mask write or a classify.
// a write loads one clause's positive and negated include masks in the cycle
// it is accepted and gives no result. a classify reads one clause per cycle
// from the include store over min(clauses_in_use, CLAUSES) clauses, a rate
// set by the single store read port, then moves the result into the output
// register. writes can be taken every cycle while no classify is in progress.
// the next request is taken as soon as the result is registered, even while
// it waits on m_tready. a stalled receiver holds at most one result; a
// further classify then waits in its final cycle until the register frees.
// after reset the store is swept to zero, one entry per cycle, over all
// CLAUSES entries while s_tready stays low; apb writes are taken throughout.
// clauses_in_use is written through the apb port at address 0; the user must
// write it only while idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module tsetlin_clause_vote_inference_unit #(
  parameter int CLAUSES  = tcvi_pkg::CLAUSES_DEFAULT,
  parameter int FEATURES = tcvi_pkg::FEATURES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // clause_index[7:0], include_positive[39:8], include_negated[71:40],
  // feature_bits[103:72]
  input  logic [103:0] s_tdata,
  // req_type[0]
  input  logic [0:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // vote_sum[8:0], prediction[9], zero[15:10]
  output logic [15:0]  m_tdata
);

  logic [tcvi_pkg::CFG_W-1:0] clauses_in_use;
  logic                       cfg_hit;
  tcvi_pkg::cmd_t             cmd;
  tcvi_pkg::sts_t             sts;
  logic signed [tcvi_pkg::SUM_W-1:0] vote_sum;
  logic                       prediction;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr == 2'(4 * tcvi_pkg::REG_CLAUSES_IN_USE));
  assign prdata  = cfg_hit ? 32'(clauses_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clauses_in_use <= tcvi_pkg::CFG_W'(tcvi_pkg::CFG_RESET);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      clauses_in_use <= pwdata[tcvi_pkg::CFG_W-1:0];
    end
  end

  tcvi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser[0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcvi_dp #(
    .CLAUSES  (CLAUSES),
    .FEATURES (FEATURES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .clauses_in_use   (clauses_in_use),
    .clause_index     (s_tdata[7:0]),
    .include_positive (s_tdata[39:8]),
    .include_negated  (s_tdata[71:40]),
    .feature_bits     (s_tdata[103:72]),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .vote_sum         (vote_sum),
    .prediction       (prediction)
  );

  assign m_tdata = {6'd0, prediction, vote_sum};

endmodule

>>> dv/tcvi_vote_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcvi_vote_checker
// watches the apb port and both streams of the clause vote inference unit,
// keeps its own copy of the include store and clause count, predicts the
// vote for every classify request and compares each result as it leaves
// ---------------------------------------------------------------------------
module tcvi_vote_checker #(
  parameter int CLAUSES  = tcvi_pkg::CLAUSES_DEFAULT,
  parameter int FEATURES = tcvi_pkg::FEATURES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // clause_index[7:0], include_positive[39:8], include_negated[71:40],
  // feature_bits[103:72]
  input  logic [103:0] s_tdata,
  // req_type[0]
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // vote_sum[8:0], prediction[9], zero[15:10]
  input  logic [15:0]  m_tdata,
  output int           fail_count,
  output int           pending
);

  localparam logic [1:0] CFG_ADDR = 2'(4 * tcvi_pkg::REG_CLAUSES_IN_USE);
  localparam logic [tcvi_pkg::MASK_W-1:0] FEAT_MASK =
    {tcvi_pkg::MASK_W{1'b1}} >> (tcvi_pkg::MASK_W - FEATURES);
  localparam int SUM_HI = 255;
  localparam int SUM_LO = -256;

  typedef struct packed {
    logic signed [tcvi_pkg::SUM_W-1:0] vote_sum;
    logic                              prediction;
  } vote_result_t;

  // low half positive mask, high half negated mask
  logic [2*tcvi_pkg::MASK_W-1:0] clause_masks [CLAUSES];
  logic [tcvi_pkg::CFG_W-1:0]    clauses_cfg;
  vote_result_t                  vote_q [$];
  vote_result_t                  want;

  function automatic vote_result_t predict_vote(
    input logic [tcvi_pkg::MASK_W-1:0] feats);
    int                          sum;
    int                          lim;
    logic [tcvi_pkg::MASK_W-1:0] pos;
    logic [tcvi_pkg::MASK_W-1:0] neg;
    logic [tcvi_pkg::MASK_W-1:0] f;
    vote_result_t                r;
    sum = 0;
    f   = feats & FEAT_MASK;
    lim = (int'(clauses_cfg) > CLAUSES) ? CLAUSES : int'(clauses_cfg);
    for (int c = 0; c < lim; c++) begin
      pos = clause_masks[c][tcvi_pkg::MASK_W-1:0];
      neg = clause_masks[c][2*tcvi_pkg::MASK_W-1:tcvi_pkg::MASK_W];
      // an empty clause never fires
      if ((pos | neg) != '0 && (f & pos) == pos && (~f & neg) == neg) begin
        if (c % 2 == 0) sum++;
        else sum--;
      end
    end
    if (sum > SUM_HI) sum = SUM_HI;
    if (sum < SUM_LO) sum = SUM_LO;
    r.vote_sum   = sum[tcvi_pkg::SUM_W-1:0];
    r.prediction = (sum >= 1);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLAUSES; i++) clause_masks[i] = '0;
      clauses_cfg = tcvi_pkg::CFG_W'(tcvi_pkg::CFG_RESET);
      vote_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
        clauses_cfg = pwdata[tcvi_pkg::CFG_W-1:0];

      // results first, so a request taken on the same edge cannot cover a stray one
      if (m_tvalid && m_tready) begin
        if (vote_q.size() == 0) begin
          fail_count++;
          $display("%t result with no request waiting: vote_sum %0d prediction %0b",
                   $time, $signed(m_tdata[tcvi_pkg::SUM_W-1:0]),
                   m_tdata[tcvi_pkg::SUM_W]);
        end else begin
          want = vote_q.pop_front();
          if (m_tdata[tcvi_pkg::SUM_W-1:0] !== want.vote_sum) begin
            fail_count++;
            $display("%t vote_sum mismatch: expected %0d actual %0d", $time,
                     want.vote_sum, $signed(m_tdata[tcvi_pkg::SUM_W-1:0]));
          end
          if (m_tdata[tcvi_pkg::SUM_W] !== want.prediction) begin
            fail_count++;
            $display("%t prediction mismatch: expected %0b actual %0b", $time,
                     want.prediction, m_tdata[tcvi_pkg::SUM_W]);
          end
          if (m_tdata[15:tcvi_pkg::SUM_W+1] !== '0) begin
            fail_count++;
            $display("%t padding mismatch: expected 0 actual %h", $time,
                     m_tdata[15:tcvi_pkg::SUM_W+1]);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == tcvi_pkg::REQ_WRITE) begin
          if (int'(s_tdata[tcvi_pkg::INDEX_W-1:0]) < CLAUSES)
            clause_masks[s_tdata[tcvi_pkg::INDEX_W-1:0]] =
              {s_tdata[71:40] & FEAT_MASK, s_tdata[39:8] & FEAT_MASK};
        end else begin
          vote_q.insert(vote_q.size(), predict_vote(s_tdata[103:72]));
        end
      end

      pending = vote_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stimulus for the clause vote inference unit: directed mask writes and
// classify requests, then randomised write/classify batches over several
// clause counts, with random idling on both streams and a stall watchdog
// ---------------------------------------------------------------------------
module tb_top;

  localparam int          STALL_LIMIT = 20000;
  localparam int          SETTLE      = 300;
  localparam logic [1:0]  CFG_ADDR    = 2'(4 * tcvi_pkg::REG_CLAUSES_IN_USE);

  logic         clk;
  logic         rst;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [1:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;

  int           fail_count;
  int           pending;
  int           idle_cycles;
  logic         steady;
  logic [8:0]   cur_cfg;
  logic [31:0]  base_pattern;

  tsetlin_clause_vote_inference_unit dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tcvi_vote_checker chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever @(negedge clk) m_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // stall watchdog: cycles in which nothing moves on any port
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%t stalled for %0d cycles, %0d results outstanding", $time,
             STALL_LIMIT, pending);
    $display("** tsetlin_clause_vote_inference_unit: FAILED **");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back requests need no extra drive
  task automatic push_request(input logic kind, input logic [103:0] data);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [31:0] pos,
                            input logic [31:0] neg);
    push_request(tcvi_pkg::REQ_WRITE, {32'($urandom), neg, pos, idx});
  endtask

  task automatic send_classify(input logic [31:0] feats);
    push_request(tcvi_pkg::REQ_CLASSIFY,
                 {feats, 32'($urandom), 32'($urandom), 8'($urandom)});
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_clause_count(input logic [8:0] val);
    wait_results_drained();
    repeat (SETTLE) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR;
    pwdata  <= {23'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = val;
  endtask

  // batches of mask writes mostly shaped to fire on a shared pattern,
  // each followed by a few classify requests near that pattern
  task automatic run_batches(input int n_items);
    int          sent;
    int          max_idx;
    int          pick;
    logic [7:0]  idx;
    logic [31:0] pos;
    logic [31:0] neg;
    logic [31:0] one_bit;
    logic [31:0] feats;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 40) base_pattern = $urandom;
      if ($urandom_range(0, 99) < 10) begin
        send_classify($urandom);
        sent++;
      end
      max_idx = (cur_cfg == 0 || cur_cfg > 256) ? 255 : int'(cur_cfg) - 1;
      repeat ($urandom_range(1, 12)) begin
        idx     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, max_idx));
        one_bit = 32'h1 << $urandom_range(0, 31);
        pick    = $urandom_range(0, 9);
        if (pick <= 5) begin
          pos = base_pattern & $urandom & $urandom & $urandom;
          neg = ~base_pattern & $urandom & $urandom & $urandom;
        end else if (pick == 6) begin
          // literal and its negation together
          pos = ($urandom & $urandom & $urandom) | one_bit;
          neg = ($urandom & $urandom & $urandom) | one_bit;
        end else if (pick == 7) begin
          pos = '0;
          neg = '0;
        end else begin
          pos = $urandom;
          neg = $urandom;
        end
        send_write(idx, pos, neg);
        sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3, 4: feats = base_pattern;
          5, 6:          feats = base_pattern ^ (32'h1 << $urandom_range(0, 31));
          7:             feats = $urandom;
          8:             feats = '0;
          default:       feats = '1;
        endcase
        send_classify(feats);
        sent++;
      end
      if ($urandom_range(0, 99) < 3) wait_results_drained();
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = tcvi_pkg::REQ_WRITE;
    steady       = 1'b0;
    cur_cfg      = 9'(tcvi_pkg::CFG_RESET);
    base_pattern = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty store after reset
    send_classify(32'h0000_0000);
    send_classify(32'hffff_ffff);
    send_write(8'd0,   32'h0000_0001, 32'h0000_0000);
    send_write(8'd1,   32'h0000_0000, 32'h8000_0000);
    send_write(8'd2,   32'h0000_0020, 32'h0000_0020);
    send_write(8'd3,   32'h0000_0000, 32'h0000_0000);
    send_write(8'd4,   32'h0000_0000, 32'hffff_ffff);
    send_write(8'd255, 32'hffff_ffff, 32'h0000_0000);
    send_write(8'd254, 32'h8000_0000, 32'h7fff_ffff);
    send_classify(32'hffff_ffff);
    send_classify(32'h0000_0000);
    send_classify(32'h0000_0001);
    send_classify(32'h8000_0000);
    send_classify(32'haaaa_aaaa);
    set_clause_count(9'd1);
    send_classify(32'hffff_ffff);
    send_classify(32'h0000_0000);
    set_clause_count(9'd0);
    send_classify(32'h0000_0001);
    set_clause_count(9'd511);
    send_classify(32'h8000_0000);
    send_classify(32'hffff_ffff);
    set_clause_count(9'd257);
    send_classify(32'h0000_0000);

    // every even clause on feature 0, every odd one on feature 1: full-scale sums
    set_clause_count(9'd256);
    for (int c = 0; c < 256; c++)
      send_write(8'(c), (c % 2 == 0) ? 32'h1 : 32'h2, 32'h0);
    send_classify(32'h0000_0001);
    send_classify(32'h0000_0002);
    send_classify(32'h0000_0003);
    set_clause_count(9'd2);
    send_classify(32'h0000_0001);
    send_classify(32'h0000_0002);

    set_clause_count(9'd256);
    run_batches(125);
    set_clause_count(9'd1);
    run_batches(125);
    set_clause_count(9'd17);
    steady = 1'b1;
    run_batches(125);
    steady = 1'b0;
    set_clause_count(9'd0);
    run_batches(125);
    set_clause_count(9'd511);
    run_batches(125);
    set_clause_count(9'd2);
    run_batches(125);
    set_clause_count(9'd257);
    run_batches(125);
    set_clause_count(9'd255);
    run_batches(125);
    set_clause_count(9'($urandom_range(3, 64)));
    run_batches(125);
    set_clause_count(9'($urandom_range(0, 511)));
    run_batches(125);
    set_clause_count(9'($urandom_range(1, 40)));
    run_batches(125);

    wait_results_drained();
    repeat (SETTLE) @(negedge clk);
    if (pending != 0)
      $display("%t %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** tsetlin_clause_vote_inference_unit: PASSED **");
    end else begin
      $display("** tsetlin_clause_vote_inference_unit: FAILED **");
    end
    $finish;
  end

endmodule
